@@ design/memt_pkg.sv @@
package memt_pkg;

  localparam int unsigned RingLen  = 175;
  localparam int unsigned LagMid   = 45;
  localparam int unsigned LagOut   = 4;
  localparam int unsigned UpperBits = 13;
  localparam int unsigned AccLShift = 33;
  localparam int unsigned AccRShift = 13;
  localparam int unsigned TemperShift = 5;
  localparam int unsigned SeedShift = 62;

  localparam logic [63:0] TwistConst  = 64'hddbc_d6e5_25e1_c757;
  localparam logic [63:0] TemperMask  = 64'hbd2d_1251_e589_593f;
  localparam logic [63:0] SeedMult    = 64'd6364136223846793005;
  localparam logic [31:0] SeedMultLo  = SeedMult[31:0];
  localparam logic [31:0] SeedMultHi  = SeedMult[63:32];

  localparam logic OpSeed = 1'b0;
  localparam logic OpNext = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEED = 2'b10
  } memt_state_e;

  // One word produced by the seed sequencer.
  typedef struct packed {
    logic        vld;
    logic        last;
    logic [63:0] word;
  } memt_seed_word_t;

endpackage

@@ design/memt_cell.sv @@
module memt_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  logic [63:0] word_i,
  output logic [63:0] word_o
);

  logic [63:0] word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

@@ design/memt_seed_unit.sv @@
module memt_seed_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [63:0]              seed_i,
  output memt_pkg::memt_seed_word_t word_o
);

  localparam logic [1:0] PhLoLo = 2'd0;
  localparam logic [1:0] PhLoHi = 2'd1;
  localparam logic [1:0] PhHiLo = 2'd2;
  localparam logic [1:0] PhSum  = 2'd3;

  logic        busy_q;
  logic [1:0]  ph_q;
  logic [7:0]  k_q;
  logic [63:0] y_q, y_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] word;

  assign mul_a  = (ph_q == PhHiLo) ? y_q[63:32] : y_q[31:0];
  assign mul_b  = (ph_q == PhLoHi) ? memt_pkg::SeedMultHi : memt_pkg::SeedMultLo;
  assign prod_d = 64'(mul_a) * 64'(mul_b);
  assign word   = acc_q + {prod_q[31:0], 32'd0};
  assign y_d    = word ^ (word >> memt_pkg::SeedShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PhLoLo;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      ph_q   <= PhLoLo;
      k_q    <= 8'd1;
    end else if (busy_q) begin
      ph_q <= ph_q + 2'd1;
      if (ph_q == PhSum) begin
        k_q <= k_q + 8'd1;
        if (k_q == 8'(memt_pkg::RingLen)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      y_q <= seed_i ^ (seed_i >> memt_pkg::SeedShift);
    end else if (busy_q) begin
      case (ph_q)
        PhLoLo: prod_q <= prod_d;
        PhLoHi: begin
          acc_q  <= prod_q + {56'd0, k_q};
          prod_q <= prod_d;
        end
        PhHiLo: begin
          acc_q  <= acc_q + {prod_q[31:0], 32'd0};
          prod_q <= prod_d;
        end
        PhSum:   y_q <= y_d;
        default: ;
      endcase
    end
  end

  assign word_o.vld  = busy_q && (ph_q == PhSum);
  assign word_o.last = (k_q == 8'(memt_pkg::RingLen));
  assign word_o.word = word;

endmodule

@@ design/memt_64bit_random_generator.sv @@
// 64-bit random word generator with a 175-word twisted ring. A next transaction
// (operation 1) is taken every cycle while the two-entry output buffer has room
// and no seed is running; its word is registered into the output buffer before it
// reaches the output. The ring is a chain of 175 word cells that rotates by one on
// each next, so the taps sit at fixed cells. A seed transaction (operation 0) gives
// no word and holds in_ready_o low after it is taken until the seed sequencer has
// built each of the 174 ring words and the accumulator, each in the LoLo, LoHi,
// HiLo and Sum phases on one shared 32x32 multiplier. After reset the ring and
// accumulator are zero and the block returns zeros until it is seeded.
module memt_64bit_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [63:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] random_word_o
);

  localparam int unsigned Last = memt_pkg::RingLen - 1;

  memt_pkg::memt_state_e     state_q, state_d;
  memt_pkg::memt_seed_word_t sd;

  logic [63:0] cell_w [memt_pkg::RingLen];
  logic [63:0] tail_w;
  logic        shift;
  logic        in_acc, next_acc, seed_acc;
  logic [63:0] acc_q, acc_d;
  logic [63:0] x, w, res;
  logic [1:0]  cnt_q;
  logic [63:0] slot0_q, slot1_q;
  logic        pop;

  assign in_ready_o = (state_q == memt_pkg::ST_IDLE) && (cnt_q != 2'd2);
  assign in_acc     = in_valid_i && in_ready_o;
  assign next_acc   = in_acc && (operation_i == memt_pkg::OpNext);
  assign seed_acc   = in_acc && (operation_i == memt_pkg::OpSeed);

  // Twist at position 0 of the chain.
  assign x = {cell_w[0][63:64-memt_pkg::UpperBits], cell_w[1][63-memt_pkg::UpperBits:0]};
  assign acc_d = (x >> 1) ^ (x[0] ? memt_pkg::TwistConst : 64'd0)
               ^ cell_w[memt_pkg::LagMid] ^ (acc_q ^ (acc_q << memt_pkg::AccLShift));
  assign w   = x ^ (acc_d ^ (acc_d >> memt_pkg::AccRShift));
  assign res = (w ^ (w << memt_pkg::TemperShift))
             ^ (cell_w[memt_pkg::LagOut] & memt_pkg::TemperMask);

  always_comb begin
    tail_w = sd.word;
    if (next_acc) begin
      tail_w = w;
    end else if (seed_acc) begin
      tail_w = seed_value_i;
    end
  end

  assign shift = next_acc || seed_acc || (sd.vld && !sd.last);

  for (genvar k = 0; k < memt_pkg::RingLen; k++) begin : g_cell
    if (k == Last) begin : g_tail
      memt_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .word_i (tail_w),
        .word_o (cell_w[k])
      );
    end else begin : g_body
      memt_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .word_i (cell_w[k+1]),
        .word_o (cell_w[k])
      );
    end
  end

  memt_seed_unit u_seed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(seed_acc),
    .seed_i (seed_value_i),
    .word_o (sd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      memt_pkg::ST_IDLE: if (seed_acc) state_d = memt_pkg::ST_SEED;
      memt_pkg::ST_SEED: if (sd.vld && sd.last) state_d = memt_pkg::ST_IDLE;
      default:           state_d = memt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= memt_pkg::ST_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      if (next_acc) begin
        acc_q <= acc_d;
      end else if (sd.vld && sd.last) begin
        acc_q <= sd.word;
      end
    end
  end

  // Two-entry output buffer.
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, next_acc} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_acc && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
      slot0_q <= res;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
    if (next_acc && (cnt_q == 2'd1) && !pop) begin
      slot1_q <= res;
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign random_word_o = slot0_q;

endmodule

@@ design/memt_chk.sv @@
module memt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        operation_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] random_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(random_word_o))
    else $error("stalled output word changed");

  a_seed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == memt_pkg::OpSeed) |=> !in_ready_o)
    else $error("input taken while seeding");

  a_word_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && (operation_i == memt_pkg::OpNext)))
    else $error("output word without a next transaction");

endmodule

bind memt_64bit_random_generator memt_chk u_memt_chk (.*);

@@ verif/tb_memt_64bit_random_generator.sv @@
`timescale 1ns / 100ps

module tb_memt_64bit_random_generator;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 800;
  localparam int unsigned RandomItems = 1450;
  localparam int unsigned NumRows     = 20;
  localparam logic [63:0] UpperMask   = ~(64'hffff_ffff_ffff_ffff >> memt_pkg::UpperBits);
  localparam logic [63:0] LowerMask   = ~UpperMask;
  localparam logic [63:0] AllOnes     = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic        op;
    logic [63:0] seed;
    logic        fixed;
    logic [63:0] word;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready_o;
  logic        in_op     = memt_pkg::OpNext;
  logic [63:0] in_seed   = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [63:0] random_word_o;

  // Typed expectation that travels with the transaction on the input side.
  logic        row_fixed = 1'b0;
  logic [63:0] row_word  = '0;

  logic [63:0] twist_ring [memt_pkg::RingLen];
  logic [63:0] twist_acc;
  logic [7:0]  twist_pos;

  logic [63:0] expected_words [$];
  logic [63:0] predicted_word;
  logic [63:0] expected_word;
  int unsigned idle_cycles = 0;
  int unsigned errors      = 0;
  bit          send_calm   = 1'b0;
  bit          recv_calm   = 1'b0;

  stim_row_t directed_rows [NumRows] = '{
    // next before any seed runs on the zero ring
    '{memt_pkg::OpNext, 64'h0,                   1'b1, 64'h0},
    '{memt_pkg::OpNext, AllOnes,                 1'b1, 64'h0},
    '{memt_pkg::OpNext, 64'h1234_5678_9abc_def0, 1'b1, 64'h0},
    '{memt_pkg::OpSeed, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpNext, AllOnes,                 1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpSeed, AllOnes,                 1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpNext, AllOnes,                 1'b0, 64'h0},
    '{memt_pkg::OpSeed, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
    '{memt_pkg::OpSeed, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpSeed, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpNext, 64'h0,                   1'b0, 64'h0},
    '{memt_pkg::OpSeed, 64'h1,                   1'b0, 64'h0}
  };

  memt_64bit_random_generator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .operation_i  (in_op),
    .seed_value_i (in_seed),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .random_word_o(random_word_o)
  );

  always #1 clk = ~clk;

  function void reseed_ring(input logic [63:0] seed);
    logic [63:0] prev;
    twist_ring[0] = seed;
    for (int unsigned k = 1; k < memt_pkg::RingLen; k++) begin
      prev = twist_ring[k-1];
      twist_ring[k] = memt_pkg::SeedMult * (prev ^ (prev >> memt_pkg::SeedShift)) + 64'(k);
    end
    prev = twist_ring[memt_pkg::RingLen-1];
    twist_acc = memt_pkg::SeedMult * (prev ^ (prev >> memt_pkg::SeedShift))
              + 64'(memt_pkg::RingLen);
    twist_pos = '0;
  endfunction

  function logic [63:0] next_tempered_word();
    int unsigned i, i1, im, io;
    logic [63:0] x, w;
    i  = twist_pos % memt_pkg::RingLen;
    i1 = (i + 1) % memt_pkg::RingLen;
    im = (i + memt_pkg::LagMid) % memt_pkg::RingLen;
    io = (i + memt_pkg::LagOut) % memt_pkg::RingLen;
    x = (twist_ring[i] & UpperMask) | (twist_ring[i1] & LowerMask);
    twist_acc = (x >> 1) ^ (x[0] ? memt_pkg::TwistConst : 64'h0) ^ twist_ring[im]
                ^ (twist_acc ^ (twist_acc << memt_pkg::AccLShift));
    w = x ^ (twist_acc ^ (twist_acc >> memt_pkg::AccRShift));
    twist_ring[i] = w;
    twist_pos = 8'(i1);
    return (w ^ (w << memt_pkg::TemperShift)) ^ (twist_ring[io] & memt_pkg::TemperMask);
  endfunction

  task automatic issue(input logic op, input logic [63:0] seed,
                       input logic fixed, input logic [63:0] word);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_seed   <= seed;
    row_fixed <= fixed;
    row_word  <= word;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  // Drop valid and hold until every word in flight has been checked.
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        if (in_op == memt_pkg::OpNext) begin
          predicted_word = next_tempered_word();
          expected_words.push_back(row_fixed ? row_word : predicted_word);
        end else begin
          reseed_ring(in_seed);
        end
      end
      if (out_valid_o && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("random_word with no transaction pending: actual %h", random_word_o);
          errors++;
        end else begin
          expected_word = expected_words.pop_front();
          if (random_word_o !== expected_word) begin
            $error("random_word mismatch: expected %h, actual %h",
                   expected_word, random_word_o);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_memt_64bit_random_generator failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned run;
    bit          pressure_done;
    logic [63:0] seed_pick;
    sent = 0;
    pressure_done = 1'b0;
    for (int unsigned k = 0; k < memt_pkg::RingLen; k++) twist_ring[k] = '0;
    twist_acc = '0;
    twist_pos = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      issue(directed_rows[r].op, directed_rows[r].seed,
            directed_rows[r].fixed, directed_rows[r].word);
    drain_words();

    // Usually a seed, then a run of next words; long runs wrap the ring position.
    while (sent < RandomItems) begin
      if (!pressure_done && sent >= RandomItems / 2) begin
        drain_words();
        pressure_done = 1'b1;
      end
      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 7))
          0:       seed_pick = '0;
          1:       seed_pick = AllOnes;
          default: seed_pick = {$urandom, $urandom};
        endcase
        issue(memt_pkg::OpSeed, seed_pick, 1'b0, '0);
        sent++;
      end
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(176, 400) : $urandom_range(0, 60);
      if (run > RandomItems - sent) run = RandomItems - sent;
      repeat (run) begin
        issue(memt_pkg::OpNext, {$urandom, $urandom}, 1'b0, '0);
        sent++;
      end
    end

    drain_words();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("tb_memt_64bit_random_generator passed");
    else $display("tb_memt_64bit_random_generator failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/memt_pkg.sv
design/memt_cell.sv
design/memt_seed_unit.sv
design/memt_64bit_random_generator.sv
design/memt_chk.sv
verif/tb_memt_64bit_random_generator.sv
